>>> rtl/afrc_pkg.sv
// Shared types and constants for the audio frame rate changer.
// Used by afrc_lane, afrc_dpath, afrc_ctrl and the top level; depends on nothing.
`default_nettype none

package afrc_pkg;

    localparam int FACTOR_W = 6;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Largest rate change factor; a register write keeps only the low FACTOR_W bits of pwdata.
    localparam logic [FACTOR_W-1:0] MAX_FACTOR = 6'd63;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_FACTOR   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    // Mode register values
    localparam logic MODE_DECIMATE    = 1'b0;
    localparam logic MODE_INTERPOLATE = 1'b1;

    // Source of an emitted frame
    typedef logic [1:0] t_emit_sel;
    localparam t_emit_sel EMIT_HELD   = 2'd0;
    localparam t_emit_sel EMIT_INTERP = 2'd1;
    localparam t_emit_sel EMIT_CUR    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic      accept;
        logic      div_load;
        logic      div_step;
        logic      base_latch;
        logic      interp_step;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        logic      store;
        logic      clear;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                mode;
        logic                pass;
        logic                eos;
        logic                have;
        logic [FACTOR_W-1:0] f;
        logic                out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/afrc_lane.sv
// One channel of the interpolator: restoring divider (one quotient bit per cycle)
// and the quotient/remainder accumulator that steps through j = 1 .. factor-1.
// Depends on afrc_pkg.
`default_nettype none

module afrc_lane #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire afrc_pkg::t_cmd                i_cmd,
    input  wire logic [afrc_pkg::FACTOR_W-1:0] i_f,
    input  wire logic signed [SAMPLE_BITS-1:0] i_cur,
    input  wire logic signed [SAMPLE_BITS-1:0] i_held,
    output logic signed [SAMPLE_BITS-1:0]      o_interp
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int XW = SAMPLE_BITS + 2;
    localparam int FW = afrc_pkg::FACTOR_W;

    logic                 r_neg;
    logic [DW-1:0]        r_dq;     // dividend, then quotient, then running quotient
    logic [FW-1:0]        r_rem;
    logic [DW-1:0]        r_q0;
    logic [FW-1:0]        r_r0;

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [FW:0]          div_try;
    logic [FW:0]          div_sub;
    logic                 div_ge;
    logic [FW-1:0]        n_rem_div;
    logic [FW:0]          acc_sum;
    logic [FW:0]          acc_sub;
    logic                 acc_carry;
    logic [FW-1:0]        n_rem_acc;
    logic [DW-1:0]        n_dq_acc;
    logic signed [XW-1:0] held_x;
    logic signed [XW-1:0] acc_x;
    logic signed [XW-1:0] val;

    assign diff = DW'(i_cur) - DW'(i_held);
    assign mag  = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);

    // Restoring division step: shift in the next dividend bit
    assign div_try   = {r_rem, r_dq[DW-1]};
    assign div_sub   = div_try - {1'b0, i_f};
    assign div_ge    = div_try >= {1'b0, i_f};
    assign n_rem_div = div_ge ? div_sub[FW-1:0] : div_try[FW-1:0];

    // floor(|d|*(j+1)/f) = floor(|d|*j/f) + q0 + carry of the remainder sum
    assign acc_sum   = {1'b0, r_rem} + {1'b0, r_r0};
    assign acc_sub   = acc_sum - {1'b0, i_f};
    assign acc_carry = acc_sum >= {1'b0, i_f};
    assign n_rem_acc = acc_carry ? acc_sub[FW-1:0] : acc_sum[FW-1:0];
    assign n_dq_acc  = r_dq + r_q0 + DW'(acc_carry);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= diff[DW-1];
            r_dq  <= mag;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[DW-2:0], div_ge};
            r_rem <= n_rem_div;
        end else if (i_cmd.interp_step) begin
            r_dq  <= n_dq_acc;
            r_rem <= n_rem_acc;
        end
        if (i_cmd.base_latch) begin
            r_q0 <= r_dq;
            r_r0 <= r_rem;
        end
    end

    // Truncation toward zero: apply the sign to the magnitude quotient
    assign held_x   = XW'(i_held);
    assign acc_x    = signed'({1'b0, r_dq});
    assign val      = r_neg ? (held_x - acc_x) : (held_x + acc_x);
    assign o_interp = val[SAMPLE_BITS-1:0];

    a_rem_below_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step || i_cmd.interp_step) |-> r_rem < i_f)
        else $error("lane remainder not below factor");

    a_base_rem_below_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.base_latch) |-> r_r0 < i_f)
        else $error("divider remainder not below factor");

    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.interp_step) |->
            (DW'(r_dq - $past(r_dq)) == r_q0) || (DW'(r_dq - $past(r_dq)) == DW'(r_q0 + 1'b1)))
        else $error("interpolation accumulator stepped wrong");

endmodule

`default_nettype wire

>>> rtl/afrc_dpath.sv
// Datapath: input latch, stored frame, decimation phase, two interpolation
// lanes and the output register. Driven by afrc_ctrl; depends on afrc_pkg, afrc_lane.
`default_nettype none

module afrc_dpath #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire afrc_pkg::t_cmd                i_cmd,
    output afrc_pkg::t_stat                    o_stat,
    input  wire logic                          i_cfg_mode,
    input  wire logic [afrc_pkg::FACTOR_W-1:0] i_cfg_factor,
    input  wire logic [1:0]                    i_cfg_channels,
    input  wire logic [31:0]                   i_sample_left,
    input  wire logic [31:0]                   i_sample_right,
    input  wire logic                          i_end_of_stream,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [31:0]                        o_out_left,
    output logic [31:0]                        o_out_right,
    output logic                               o_run_last
);

    localparam int FW = afrc_pkg::FACTOR_W;

    logic                          r_mode;
    logic                          r_stereo;
    logic                          r_eos;
    logic                          r_pass;
    logic                          r_have;
    logic [FW-1:0]                 r_f;
    logic signed [SAMPLE_BITS-1:0] r_cur_l;
    logic signed [SAMPLE_BITS-1:0] r_cur_r;
    logic signed [SAMPLE_BITS-1:0] r_held_l;
    logic signed [SAMPLE_BITS-1:0] r_held_r;
    logic                          r_have_held;
    logic [FW-1:0]                 r_phase;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_last;

    logic [FW-1:0]                 eff_f;
    logic [FW:0]                   phase_inc;
    logic [FW-1:0]                 n_phase;
    logic                          cfg_stereo;
    logic signed [SAMPLE_BITS-1:0] interp_l;
    logic signed [SAMPLE_BITS-1:0] interp_r;
    logic signed [SAMPLE_BITS-1:0] n_out_left;
    logic signed [SAMPLE_BITS-1:0] n_out_right;

    assign cfg_stereo = i_cfg_channels[1];

    always_comb begin
        if (i_cfg_factor == '0) begin
            eff_f = FW'(1);
        end else if (i_cfg_factor > afrc_pkg::MAX_FACTOR) begin
            eff_f = afrc_pkg::MAX_FACTOR;
        end else begin
            eff_f = i_cfg_factor;
        end
    end

    // Wrap the phase once phase+1 reaches the factor (also when it went past it)
    assign phase_inc = {1'b0, r_phase} + 1'b1;
    assign n_phase   = (phase_inc >= {1'b0, eff_f}) ? '0 : phase_inc[FW-1:0];

    // Snapshot of the item and of the settings it runs under
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_cfg_mode;
            r_stereo <= cfg_stereo;
            r_eos    <= i_end_of_stream;
            r_f      <= eff_f;
            r_pass   <= (r_phase == '0);
            r_have   <= r_have_held;
            r_cur_l  <= i_sample_left[SAMPLE_BITS-1:0];
            r_cur_r  <= cfg_stereo ? i_sample_right[SAMPLE_BITS-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_held <= 1'b0;
            r_phase     <= '0;
            r_held_l    <= '0;
            r_held_r    <= '0;
        end else if (i_cmd.clear) begin
            r_have_held <= 1'b0;
            r_phase     <= '0;
            r_held_l    <= '0;
            r_held_r    <= '0;
        end else begin
            if (i_cmd.accept && (i_cfg_mode == afrc_pkg::MODE_DECIMATE)) begin
                r_phase <= n_phase;
            end
            if (i_cmd.store) begin
                r_held_l    <= r_cur_l;
                r_held_r    <= r_cur_r;
                r_have_held <= 1'b1;
            end
        end
    end

    afrc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_f      (r_f),
        .i_cur    (r_cur_l),
        .i_held   (r_held_l),
        .o_interp (interp_l)
    );

    afrc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_f      (r_f),
        .i_cur    (r_cur_r),
        .i_held   (r_held_r),
        .o_interp (interp_r)
    );

    always_comb begin
        case (i_cmd.emit_sel)
            afrc_pkg::EMIT_HELD: begin
                n_out_left  = r_held_l;
                n_out_right = r_held_r;
            end
            afrc_pkg::EMIT_INTERP: begin
                n_out_left  = interp_l;
                n_out_right = interp_r;
            end
            default: begin
                n_out_left  = r_cur_l;
                n_out_right = r_cur_r;
            end
        endcase
    end

    // Output register: holds a finished item until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_left  <= n_out_left;
            r_out_right <= r_stereo ? n_out_right : '0;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = 32'(r_out_left);
    assign o_out_right = 32'(r_out_right);
    assign o_run_last  = r_out_last;

    assign o_stat.mode     = r_mode;
    assign o_stat.pass     = r_pass;
    assign o_stat.eos      = r_eos;
    assign o_stat.have     = r_have;
    assign o_stat.f        = r_f;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

>>> rtl/afrc_ctrl.sv
// Sequencer for one item at a time: decide, divide, emit the stored,
// interpolated and final frames. Talks to afrc_dpath through afrc_pkg::t_cmd/t_stat.
`default_nettype none

module afrc_ctrl #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire afrc_pkg::t_stat i_stat,
    output afrc_pkg::t_cmd       o_cmd
);

    localparam int CW = afrc_pkg::CNT_W;
    localparam int FW = afrc_pkg::FACTOR_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_HELD   = 3'd3;
    localparam logic [2:0] S_INTERP = 3'd4;
    localparam logic [2:0] S_CUR    = 3'd5;

    // SAMPLE_BITS+1 division steps: counter runs 0 .. SAMPLE_BITS
    localparam logic [CW-1:0] DIV_LAST = CW'(SAMPLE_BITS);

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] cnt_inc;
    logic          f_one;
    logic          j_last;

    assign cnt_inc = r_cnt + 1'b1;
    assign f_one   = (i_stat.f == FW'(1));
    assign j_last  = (cnt_inc == i_stat.f);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.mode == afrc_pkg::MODE_DECIMATE) begin
                    if (i_stat.pass) begin
                        n_state = S_CUR;
                    end else begin
                        o_cmd.clear = i_stat.eos;
                        n_state     = S_IDLE;
                    end
                end else if (i_stat.have) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = i_stat.eos ? S_CUR : S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = cnt_inc;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_HELD;
                end
            end
            S_HELD: begin
                o_cmd.base_latch = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = afrc_pkg::EMIT_HELD;
                    o_cmd.emit_last = f_one && !i_stat.eos;
                    if (f_one) begin
                        o_cmd.store = 1'b1;
                        n_state     = i_stat.eos ? S_CUR : S_IDLE;
                    end else begin
                        n_cnt   = CW'(1);
                        n_state = S_INTERP;
                    end
                end
            end
            S_INTERP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_sel    = afrc_pkg::EMIT_INTERP;
                    o_cmd.emit_last   = j_last && !i_stat.eos;
                    o_cmd.interp_step = 1'b1;
                    if (j_last) begin
                        o_cmd.store = 1'b1;
                        n_state     = i_stat.eos ? S_CUR : S_IDLE;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            S_CUR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = afrc_pkg::EMIT_CUR;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clear     = i_stat.eos;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("frame emitted into a full output register");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= DIV_LAST)
        else $error("division ran past its step count");

    a_interp_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INTERP |-> (r_cnt != '0) && (r_cnt < i_stat.f))
        else $error("interpolation index out of range");

endmodule

`default_nettype wire

>>> rtl/audio_frame_rate_changer.sv
// Audio frame rate changer: decimates by keeping every factor-th frame, or upsamples by
// linear interpolation between stored and current frame, one or two channels per item.
// Items are handled one at a time. A decimate-mode item is accepted and decided, and a
// passed frame is then emitted. An interpolate-mode item with no stored frame is stored
// (and emitted at end of stream). An interpolate-mode item with a stored frame runs the
// one-bit-per-cycle restoring divider that forms (cur-prev)/factor, then emits the stored
// frame, the interpolated frames and any end-of-stream frame, one per cycle unless the
// output stalls. The output register lets the next item enter while the last frame waits.
// Configuration is an APB-style port at byte addresses 0 (mode), 4 (factor), 8 (channels).
// Depends on afrc_pkg, afrc_ctrl, afrc_dpath, afrc_lane.
`default_nettype none

module audio_frame_rate_changer #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [afrc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [afrc_pkg::DATA_W-1:0] pwdata,
    output logic [afrc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [31:0]                 i_sample_left,
    input  wire logic [31:0]                 i_sample_right,
    input  wire logic                        i_end_of_stream,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [31:0]                      o_out_left,
    output logic [31:0]                      o_out_right,
    output logic                             o_run_last
);

    localparam int FW = afrc_pkg::FACTOR_W;
    localparam int DW = afrc_pkg::DATA_W;

    logic            r_mode;
    logic [FW-1:0]   r_factor;
    logic [1:0]      r_channels;
    logic            cfg_wr;
    logic [FW-1:0]   wr_factor;
    afrc_pkg::t_cmd  cmd;
    afrc_pkg::t_stat stat;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign wr_factor = (pwdata[FW-1:0] > afrc_pkg::MAX_FACTOR) ? afrc_pkg::MAX_FACTOR
                                                               : pwdata[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= afrc_pkg::MODE_DECIMATE;
            r_factor   <= FW'(1);
            r_channels <= 2'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                afrc_pkg::REG_MODE:     r_mode     <= pwdata[0];
                afrc_pkg::REG_FACTOR:   r_factor   <= wr_factor;
                afrc_pkg::REG_CHANNELS: r_channels <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            afrc_pkg::REG_MODE:     prdata = DW'(r_mode);
            afrc_pkg::REG_FACTOR:   prdata = DW'(r_factor);
            afrc_pkg::REG_CHANNELS: prdata = DW'(r_channels);
            default:                prdata = '0;
        endcase
    end

    afrc_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    afrc_dpath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_mode      (r_mode),
        .i_cfg_factor    (r_factor),
        .i_cfg_channels  (r_channels),
        .i_sample_left   (i_sample_left),
        .i_sample_right  (i_sample_right),
        .i_end_of_stream (i_end_of_stream),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_left      (o_out_left),
        .o_out_right     (o_out_right),
        .o_run_last      (o_run_last)
    );

endmodule

`default_nettype wire
